// File: design/hatp_pkg.sv
// ----------------------------------------------------------------------------
// hatp_pkg: shared result type and constants for the hex array text parser
// Character codes the parser reacts to and the result word layout.
// ----------------------------------------------------------------------------
package hatp_pkg;

   // characters of interest
   localparam logic [7:0] CH_OPEN  = 8'h7B;  // '{'
   localparam logic [7:0] CH_CLOSE = 8'h7D;  // '}'
   localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
   localparam logic [7:0] CH_LF    = 8'h0A;  // newline
   localparam logic [7:0] CH_CR    = 8'h0D;  // carriage return
   localparam logic [7:0] CH_TAB   = 8'h09;  // tab
   localparam logic [7:0] CH_SPACE = 8'h20;  // blank
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
   localparam logic [7:0] CH_UX    = 8'h58;  // 'X'

   // value given for a token with too many significant digits
   localparam logic [7:0] BYTE_SAT = 8'hFF;
   localparam logic [3:0] SIG_MAX  = 4'd8;

   // one result word
   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data_byte;
      logic       end_flag;
      logic       status;
   } result_type;

endpackage

// File: design/hatp_core.sv
// ----------------------------------------------------------------------------
// hatp_core: parse state and per-character decode
// Holds parse and token state; decodes one character per accepted word and
// produces the result word for the output register.
// ----------------------------------------------------------------------------
module hatp_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            char_in,
   input  logic                  last_char,
   output logic                  res_valid,
   output hatp_pkg::result_type  res
);

   typedef enum logic [2:0] {
      PH_SEEK,
      PH_ARRAY,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      TK_LEAD,
      TK_ZERO,
      TK_PFX,
      TK_DIGIT,
      TK_STOP,
      TK_SKIP
   } token_type;

   phase_type  phase_ff, phase_in;
   token_type  tok_ff, tok_in;
   logic [7:0] accum_ff, accum_in;
   logic [3:0] sig_ff, sig_in;
   logic [1:0] len_ff, len_in;
   logic       any_ff, any_in;

   // token state after feeding the character
   token_type  tok_f;
   logic [7:0] accum_f;
   logic [3:0] sig_f;
   logic [1:0] len_f;

   logic       is_hex;
   logic [3:0] hex_val;
   logic       closer;
   logic       endf;

   // hex digit decode
   always_comb begin
      is_hex  = 1'b1;
      hex_val = 4'd0;
      if (char_in >= 8'h30 && char_in <= 8'h39) begin
         hex_val = 4'(char_in - 8'h30);
      end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
         hex_val = 4'(char_in - 8'h57);
      end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
         hex_val = 4'(char_in - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign closer = (char_in == hatp_pkg::CH_COMMA) || (char_in == hatp_pkg::CH_LF) ||
                   (char_in == hatp_pkg::CH_CLOSE);

   // token feed
   always_comb begin
      tok_f   = tok_ff;
      accum_f = accum_ff;
      sig_f   = sig_ff;
      len_f   = len_ff;
      if (!closer) begin
         unique case (tok_ff)
            TK_LEAD: begin
               if (char_in != hatp_pkg::CH_SPACE && char_in != hatp_pkg::CH_TAB &&
                   char_in != hatp_pkg::CH_CR) begin
                  len_f = 2'd1;
                  tok_f = (char_in == hatp_pkg::CH_ZERO) ? TK_ZERO : TK_SKIP;
               end
            end
            TK_ZERO: begin
               len_f = 2'd2;
               tok_f = (char_in == hatp_pkg::CH_LX || char_in == hatp_pkg::CH_UX) ?
                       TK_PFX : TK_SKIP;
            end
            TK_PFX, TK_DIGIT: begin
               len_f = 2'd3;
               if (is_hex) begin
                  tok_f   = TK_DIGIT;
                  accum_f = {accum_ff[3:0], hex_val};
                  // leading zeros are not significant; count saturates past eight
                  if (!(sig_ff == 4'd0 && hex_val == 4'd0) && sig_ff <= hatp_pkg::SIG_MAX)
                     sig_f = sig_ff + 4'd1;
               end else begin
                  tok_f = TK_STOP;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // parse step
   always_comb begin
      phase_in = phase_ff;
      tok_in   = tok_ff;
      accum_in = accum_ff;
      sig_in   = sig_ff;
      len_in   = len_ff;
      any_in   = any_ff;
      res      = '0;
      endf     = 1'b0;
      unique case (phase_ff)
         PH_DONE: begin
            if (last_char) phase_in = PH_SEEK;
         end
         PH_ARRAY: begin
            tok_in   = tok_f;
            accum_in = accum_f;
            sig_in   = sig_f;
            len_in   = len_f;
            if (closer || last_char) begin
               if (len_f == 2'd3 && (tok_f == TK_DIGIT || tok_f == TK_STOP)) begin
                  res.byte_valid = 1'b1;
                  res.data_byte  = (sig_f > hatp_pkg::SIG_MAX) ? hatp_pkg::BYTE_SAT : accum_f;
                  any_in         = 1'b1;
               end
               tok_in   = TK_LEAD;
               accum_in = '0;
               sig_in   = '0;
               len_in   = '0;
            end
            endf = (char_in == hatp_pkg::CH_CLOSE) || last_char;
         end
         default: begin
            // seeking the open brace
            if (char_in == hatp_pkg::CH_OPEN) begin
               phase_in = PH_ARRAY;
               tok_in   = TK_LEAD;
               accum_in = '0;
               sig_in   = '0;
               len_in   = '0;
            end
            endf = last_char;
         end
      endcase
      if (endf) begin
         res.end_flag = 1'b1;
         res.status   = ~any_in;
         phase_in     = PH_DONE;
      end
      // end of text returns everything to reset
      if (last_char) begin
         phase_in = PH_SEEK;
         tok_in   = TK_LEAD;
         accum_in = '0;
         sig_in   = '0;
         len_in   = '0;
         any_in   = 1'b0;
      end
   end

   assign res_valid = res.byte_valid || res.end_flag;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         tok_ff   <= TK_LEAD;
         accum_ff <= '0;
         sig_ff   <= '0;
         len_ff   <= '0;
         any_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         tok_ff   <= tok_in;
         accum_ff <= accum_in;
         sig_ff   <= sig_in;
         len_ff   <= len_in;
         any_ff   <= any_in;
      end
   end

endmodule

// File: design/hatp_out.sv
// ----------------------------------------------------------------------------
// hatp_out: result register
// Holds one result word; accepts a new one in the cycle the old one leaves.
// ----------------------------------------------------------------------------
module hatp_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  res_valid,
   input  hatp_pkg::result_type  res,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hatp_pkg::result_type  out_res
);

   logic                 valid_ff, valid_in;
   hatp_pkg::result_type res_ff;

   // free when empty or draining this cycle
   assign room = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) valid_in = 1'b0;
      if (accept && res_valid) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept && res_valid) res_ff <= res;
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule

// File: design/hex_array_text_parser.sv
// ----------------------------------------------------------------------------
// hex_array_text_parser: parser for C array text of hex bytes
//
//   channel   dir   payload
//   req_      in    tdata = char_in[7:0], tlast = last_char
//   rsp_      out   tdata = data_byte[7:0], tlast = end_flag,
//                   tuser = {status, byte_valid}
//
// One character per cycle while the result register has room; its result word, if any, appears the next cycle.
// Throughput is set by the single decode step between state and result register, and by rsp_ stalls.
// Reset clears parse state and empties the result register.
// A result word held under a stall blocks all input until it leaves.
// ----------------------------------------------------------------------------
module hex_array_text_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic       rsp_tlast,
   output logic [1:0] rsp_tuser    // [0] byte_valid, [1] status
);

   logic                 accept;
   logic                 room;
   logic                 res_valid;
   hatp_pkg::result_type res;
   hatp_pkg::result_type out_res;

   assign req_tready = room;
   assign accept     = req_tvalid && room;

   hatp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_in   (req_tdata),
      .last_char (req_tlast),
      .res_valid (res_valid),
      .res       (res)
   );

   hatp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .res_valid (res_valid),
      .res       (res),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata    = out_res.data_byte;
   assign rsp_tlast    = out_res.end_flag;
   assign rsp_tuser[0] = out_res.byte_valid;
   assign rsp_tuser[1] = out_res.status;

   // a result word always carries a byte or an end
   a_word_content: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] || rsp_tlast))
      else $error("result word with neither byte nor end");

   // status is meaningful only at the end
   a_status_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> !rsp_tuser[1])
      else $error("status set without end");

   // a byte at the end means status reports bytes found
   a_byte_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast && rsp_tuser[0]) |-> !rsp_tuser[1])
      else $error("byte delivered but status says none");

   // no data without a byte
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == 8'h00))
      else $error("data set without a byte");

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hex_array_text_parser
// Feeds C array text one character per word on the req_ stream and checks every
// rsp_ word against a behavioral model of the parser, with random idle cycles
// on both streams, a drained pause, and a closing stretch at full rate.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;
   localparam int ITEM_TARGET = 1950;   // input words over the whole run
   localparam int QUIET_FROM  = 1650;   // no idling past this point

   // hex digit ranges
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_F = 8'h66;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;

   typedef enum int {SCAN_SEEK, SCAN_ARRAY, SCAN_DONE} scan_state_type;
   typedef enum int {TOK_LEAD, TOK_ZERO, TOK_PREFIX, TOK_DIGIT, TOK_STOP, TOK_SKIP}
      token_state_type;

   function automatic int hex_digit(logic [7:0] c);
      if (c >= hatp_pkg::CH_ZERO && c <= CH_NINE) return int'(c - hatp_pkg::CH_ZERO);
      if (c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
      if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
      return -1;
   endfunction

   function automatic bit is_closer(logic [7:0] c);
      return (c == hatp_pkg::CH_COMMA || c == hatp_pkg::CH_LF || c == hatp_pkg::CH_CLOSE);
   endfunction

   // Tracks parser state and the queue of result words still to come
   class scoreboard_type;
      scan_state_type       scan;
      token_state_type      tok;
      logic [7:0]           acc;
      int                   sig_count;
      int                   tok_len;
      bit                   found;
      hatp_pkg::result_type expected_q[$];
      int                   errors;
      int                   items;
      int                   array_chars;
      int                   bytes_seen;
      int                   ends_seen;

      function new();
         errors = 0;
         items = 0;
         array_chars = 0;
         bytes_seen = 0;
         ends_seen = 0;
         reset_all();
      endfunction

      function void clear_token();
         tok = TOK_LEAD;
         acc = 8'h00;
         sig_count = 0;
         tok_len = 0;
      endfunction

      function void reset_all();
         scan = SCAN_SEEK;
         found = 1'b0;
         clear_token();
      endfunction

      // advance the token recognizer by one non-closing character
      function void take_char(logic [7:0] c);
         int d;
         case (tok)
            TOK_LEAD: begin
               if (c == hatp_pkg::CH_SPACE || c == hatp_pkg::CH_TAB ||
                   c == hatp_pkg::CH_CR) return;
               tok_len = 1;
               tok = (c == hatp_pkg::CH_ZERO) ? TOK_ZERO : TOK_SKIP;
            end
            TOK_ZERO: begin
               tok_len = 2;
               tok = (c == hatp_pkg::CH_LX || c == hatp_pkg::CH_UX) ? TOK_PREFIX : TOK_SKIP;
            end
            TOK_PREFIX, TOK_DIGIT: begin
               tok_len = 3;
               d = hex_digit(c);
               if (d >= 0) begin
                  // leading zeros do not count as significant
                  if (!(sig_count == 0 && d == 0) && sig_count < 9) sig_count++;
                  acc = {acc[3:0], 4'(d)};
                  tok = TOK_DIGIT;
               end else begin
                  tok = TOK_STOP;
               end
            end
            default: ;
         endcase
      endfunction

      // one accepted input word
      function void note_char(logic [7:0] c, bit last);
         hatp_pkg::result_type r;
         bit fin;
         r = '0;
         fin = 1'b0;
         items++;
         if (scan == SCAN_DONE) begin
            if (last) reset_all();
            return;
         end
         if (scan == SCAN_SEEK) begin
            if (c == hatp_pkg::CH_OPEN) begin
               scan = SCAN_ARRAY;
               clear_token();
               array_chars++;
            end
            if (!last) return;
            fin = 1'b1;
         end else begin
            array_chars++;
            if (!is_closer(c)) take_char(c);
            if (is_closer(c) || last) begin
               if (tok_len >= 3 && (tok == TOK_DIGIT || tok == TOK_STOP)) begin
                  r.byte_valid = 1'b1;
                  r.data_byte = (sig_count > int'(hatp_pkg::SIG_MAX)) ?
                                hatp_pkg::BYTE_SAT : acc;
                  found = 1'b1;
                  bytes_seen++;
               end
               clear_token();
            end
            if (c == hatp_pkg::CH_CLOSE || last) fin = 1'b1;
         end
         if (fin) begin
            r.end_flag = 1'b1;
            r.status = !found;
            ends_seen++;
            if (last) reset_all();
            else scan = SCAN_DONE;
         end
         if (r.byte_valid || r.end_flag) expected_q = {expected_q, r};
      endfunction

      // one accepted result word
      function void check_word(logic [7:0] data, logic lst, logic [1:0] user);
         hatp_pkg::result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word: valid=%b byte=%h end=%b status=%b",
                     $time, user[0], data, lst, user[1]);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (user[0] !== want.byte_valid || data !== want.data_byte ||
             lst !== want.end_flag || user[1] !== want.status) begin
            $display("%0t: result mismatch: expected valid=%b byte=%h end=%b status=%b",
                     $time, want.byte_valid, want.data_byte, want.end_flag, want.status);
            $display("%0t:                  actual   valid=%b byte=%h end=%b status=%b",
                     $time, user[0], data, lst, user[1]);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] char_in
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] data_byte
   logic       rsp_tlast;
   logic [1:0] rsp_tuser;           // [0] byte_valid, [1] status

   scoreboard_type sb = new();
   bit             idle_on = 1'b1;
   bit             quiet = 1'b0;
   int             cycle_count = 0;
   int             texts_sent = 0;
   int             stall_left = 0;
   logic [7:0]     text_q[$];
   string          hex_chars = "0123456789abcdefABCDEF";

   hex_array_text_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d result words outstanding", $time, sb.pending());
         $display("** hex_array_text_parser: FAILED **");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   // receiver backpressure in bursts of random length
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // entered and left at a falling edge
   task automatic send_char(logic [7:0] c, bit last);
      int gap;
      if (!quiet && idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_char(c, last);
      @(negedge clock);
   endtask

   task automatic send_str(string s, bit last_at_end);
      for (int i = 0; i < s.len(); i++) send_char(s[i], last_at_end && i == s.len() - 1);
   endtask

   // hold the sender until every expected word is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // add one character to the text under construction
   function automatic void append_char(logic [7:0] c);
      text_q = {text_q, c};
   endfunction

   function automatic logic [7:0] pick_junk(bit need_nonhex);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (is_closer(c) || (need_nonhex && hex_digit(c) >= 0));
      return c;
   endfunction

   function automatic logic [7:0] pick_hex();
      return hex_chars[$urandom_range(0, 21)];
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 2))
         0: return hatp_pkg::CH_SPACE;
         1: return hatp_pkg::CH_TAB;
         default: return hatp_pkg::CH_CR;
      endcase
   endfunction

   function automatic void push_token();
      int kind;
      int n;
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) append_char(pick_blank());
      if (kind <= 5) begin
         // well-formed hex byte, sometimes long or with trailing junk
         append_char(hatp_pkg::CH_ZERO);
         append_char($urandom_range(0, 1) ? hatp_pkg::CH_LX : hatp_pkg::CH_UX);
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) append_char(hatp_pkg::CH_ZERO);
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 11) : $urandom_range(1, 2);
         repeat (n) append_char(pick_hex());
         if ($urandom_range(0, 4) == 0) append_char(pick_junk(1'b0));
      end else if (kind == 6) begin
         // prefix then a non-hex character
         append_char(hatp_pkg::CH_ZERO);
         append_char(hatp_pkg::CH_LX);
         append_char(pick_junk(1'b1));
         if ($urandom_range(0, 1)) append_char(pick_hex());
      end else if (kind == 7) begin
         // too short to give a byte
         n = $urandom_range(0, 2);
         if (n >= 1) append_char(hatp_pkg::CH_ZERO);
         if (n == 2) append_char($urandom_range(0, 1) ? hatp_pkg::CH_LX : hatp_pkg::CH_UX);
      end else if (kind == 8) begin
         repeat ($urandom_range(1, 4)) append_char(pick_junk(1'b0));
      end
   endfunction

   function automatic void build_text();
      int kind;
      logic [7:0] c;
      text_q.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         // noise, may or may not hold a brace
         repeat ($urandom_range(1, 8)) append_char(8'($urandom_range(0, 255)));
      end else if (kind == 1) begin
         // broken array
         append_char(hatp_pkg::CH_OPEN);
         repeat ($urandom_range(1, 10)) append_char(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 4)) begin
            do c = 8'($urandom_range(0, 255)); while (c == hatp_pkg::CH_OPEN);
            append_char(c);
         end
         append_char(hatp_pkg::CH_OPEN);
         repeat ($urandom_range(1, 8)) begin
            push_token();
            case ($urandom_range(0, 5))
               0: append_char(hatp_pkg::CH_LF);
               1: begin
                  append_char(hatp_pkg::CH_COMMA);
                  append_char(hatp_pkg::CH_LF);
               end
               default: append_char(hatp_pkg::CH_COMMA);
            endcase
         end
         push_token();
         // close with a brace and trailer, or end inside the array
         if ($urandom_range(0, 3) != 0) begin
            append_char(hatp_pkg::CH_CLOSE);
            repeat ($urandom_range(0, 3)) append_char(8'($urandom_range(0, 255)));
         end
      end
   endfunction

   task automatic send_text();
      build_text();
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
      texts_sent++;
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extreme codes before the brace, prefix only, too many digits,
      // short token, byte closed by the brace, trailer after it
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_str(" {\t0xz,0X0123456789,\r0x,0xAb}q", 1'b1);
      // no brace at all
      send_str("a", 1'b1);
      // last character inside the array
      send_str("{0x7", 1'b1);
      texts_sent += 3;
      drain();

      // random texts until enough input words have gone in
      while (sb.items < ITEM_TARGET) begin
         idle_on = ($urandom_range(0, 2) != 0);
         quiet = (sb.items > QUIET_FROM);
         send_text();
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Parsed %0d texts from %0d input words: %0d inside arrays, %0d bytes, %0d ends",
               texts_sent, sb.items, sb.array_chars, sb.bytes_seen, sb.ends_seen);
      $display("Mismatches: %0d, cycles: %0d", sb.errors, cycle_count);
      if (sb.errors == 0) begin
         $display("** hex_array_text_parser: PASSED **");
      end else begin
         $display("** hex_array_text_parser: FAILED **");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/hatp_pkg.sv
design/hatp_core.sv
design/hatp_out.sv
design/hex_array_text_parser.sv
dv/testbench.sv
